/* rtl/tked_pkg.sv */
// Shared types and keysym constants for the terminal key escape decoder.
package tked_pkg;

  // Kinds of decoded events.
  localparam logic [1:0] EV_KEY    = 2'd0;
  localparam logic [1:0] EV_MOUSE  = 2'd1;
  localparam logic [1:0] EV_COLOUR = 2'd2;

  // X11 keysym values.
  localparam logic [15:0] K_ESCAPE    = 16'hFF1B;
  localparam logic [15:0] K_RETURN    = 16'hFF0D;
  localparam logic [15:0] K_BACKSPACE = 16'hFF08;
  localparam logic [15:0] K_HOME      = 16'hFF50;
  localparam logic [15:0] K_LEFT      = 16'hFF51;
  localparam logic [15:0] K_UP        = 16'hFF52;
  localparam logic [15:0] K_RIGHT     = 16'hFF53;
  localparam logic [15:0] K_DOWN      = 16'hFF54;
  localparam logic [15:0] K_PAGE_UP   = 16'hFF55;
  localparam logic [15:0] K_PAGE_DOWN = 16'hFF56;
  localparam logic [15:0] K_END       = 16'hFF57;
  localparam logic [15:0] K_F1        = 16'hFFBE;
  localparam logic [15:0] K_DELETE    = 16'hFFFF;

  // Modifier mask bits.
  localparam logic [2:0] M_NONE  = 3'd0;
  localparam logic [2:0] M_SHIFT = 3'd1;
  localparam logic [2:0] M_ALT   = 3'd2;
  localparam logic [2:0] M_CTRL  = 3'd4;

  // One decoded event as it leaves the parser.
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [15:0]       key_code;
    logic [2:0]        modifiers;
    logic [7:0]        mouse_button;
    logic signed [8:0] mouse_x;
    logic signed [8:0] mouse_y;
    logic [7:0]        colour_index;
    logic [7:0]        colour_red;
    logic [7:0]        colour_green;
    logic [7:0]        colour_blue;
  } tked_result_t;

  localparam tked_result_t NO_RESULT = '0;

endpackage

/* rtl/terminal_key_escape_decoder.sv */
// Top level of the terminal key escape decoder: input register, parser and result register.
//
// The decoder takes one raw terminal byte per request on the slave stream and turns the
// byte stream into key events (X11 keysyms with a shift/alt/control mask), X10 mouse
// reports and OSC 4 palette colour replies. A byte within a sequence produces no event;
// an event goes out on the master stream for a plain byte or when a sequence completes.
// Setting the tuser bit on a request marks end of input: right after ESC it yields Escape,
// elsewhere it drops any partial sequence. A new byte is accepted every cycle as long as
// results are taken. An accepted byte sits in the input register, and its event then
// sits in the result register, which drives the master stream. A single parser step lies
// between those registers.
// When a result waits untaken, the byte held in the input register waits with it and the
// slave side stalls once that register is full.
module terminal_key_escape_decoder
  import tked_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Slave stream: raw bytes.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] end_of_input
  // Master stream: decoded events.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [15:0] key_code, [18:16] modifiers, [26:19] mouse_button,
                                 // [35:27] mouse_x, [44:36] mouse_y, [52:45] colour_index,
                                 // [60:53] colour_red, [68:61] colour_green,
                                 // [76:69] colour_blue, [79:77] zero
  output logic [1:0]  m_tuser    // [1:0] event_kind
);

  logic         in_valid;
  logic [7:0]   in_byte_q;
  logic         in_eoi_q;
  logic         advance;
  tked_result_t res;

  // The held byte moves through the parser once the result register can take its event.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte_q <= s_tdata;
      in_eoi_q  <= s_tuser;
    end
  end

  tked_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .in_byte      (in_byte_q),
    .end_of_input (in_eoi_q),
    .res          (res)
  );

  // Result register; it loads only when the parser step produces an event.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (advance && res.valid) m_tvalid <= 1'b1;
    end
    if (advance && res.valid) begin
      m_tuser <= res.kind;
      m_tdata <= {3'b000, res.colour_blue, res.colour_green, res.colour_red,
                  res.colour_index, res.mouse_y, res.mouse_x, res.mouse_button,
                  res.modifiers, res.key_code};
    end
  end

endmodule

/* rtl/tked_parser.sv */
// Escape sequence parser: state registers and the next-state and event logic for one byte.
module tked_parser
  import tked_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   in_byte,
  input  logic         end_of_input,
  output tked_result_t res
);

  typedef enum logic [5:0] {
    S_IDLE, S_ESC, S_OSC, S_SS3, S_CSI, S_CSI_LB, S_CSI1, S_CSI1_MOD,
    S_CSI1_FIN, S_CSI2, S_CSI4, S_TILDE, S_TMOD, S_TSKIP,
    S_MB, S_MX, S_MY,
    S_C_SEMI, S_C_IDX0, S_C_IDX, S_L_R, S_L_G, S_L_B, S_L_COLON,
    S_CP0, S_CP1, S_CP2, S_CP3, S_CP4
  } state_t;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTRL  = 8'h40;
  localparam logic [7:0] CH_MOUSE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UJ    = 8'h4A;
  localparam logic [7:0] CH_UK    = 8'h4B;
  localparam logic [7:0] CH_UM    = 8'h4D;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_UR    = 8'h52;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF_   = 8'h66;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [1:0] COMP_BLUE = 2'd2;

  state_t      state, state_next;
  logic [15:0] pending_key, pending_key_next;
  logic [2:0]  pending_mods, pending_mods_next;
  logic [7:0]  held_button, held_button_next;
  logic [8:0]  held_x, held_x_next;
  logic [7:0]  index_accum, index_accum_next;
  logic [7:0]  red_hold, red_hold_next;
  logic [7:0]  green_hold, green_hold_next;
  logic [7:0]  blue_hold, blue_hold_next;
  logic [3:0]  hex_hold, hex_hold_next;
  logic [1:0]  comp, comp_next;

  logic        redo;
  logic [4:0]  hv;
  logic        is_hex;
  logic        is_digit;
  logic [7:0]  sep;
  logic [2:0]  mod_b;
  logic [11:0] idx_sum;
  logic [15:0] byte16;
  logic [15:0] ctrl16;

  // Returns 16 for a byte that is not a hex digit.
  function automatic logic [4:0] hexval(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= CH_0 && b <= CH_9) v = 5'(b - CH_0);
    else if (b >= CH_LA && b <= CH_LF_) v = 5'(b - CH_LA + 8'd10);
    else if (b >= CH_UA && b <= CH_UF) v = 5'(b - CH_UA + 8'd10);
    return v;
  endfunction

  function automatic tked_result_t key_res(input logic [15:0] code, input logic [2:0] mods);
    tked_result_t r;
    r = NO_RESULT;
    r.valid     = 1'b1;
    r.kind      = EV_KEY;
    r.key_code  = code;
    r.modifiers = mods;
    return r;
  endfunction

  always_comb begin
    hv       = hexval(in_byte);
    is_hex   = !hv[4];
    is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
    sep      = (comp < COMP_BLUE) ? CH_SLASH : CH_BEL;
    // The low three bits of 0x31 are 1, so the upper byte bits drop out.
    mod_b    = in_byte[2:0] - 3'd1;
    idx_sum  = {1'b0, index_accum, 3'b000} + {3'b000, index_accum, 1'b0}
             + {4'h0, in_byte - CH_0};
    byte16   = {8'h00, in_byte};
    ctrl16   = byte16 + {8'h00, CH_CTRL};

    state_next        = S_IDLE;
    pending_key_next  = pending_key;
    pending_mods_next = pending_mods;
    held_button_next  = held_button;
    held_x_next       = held_x;
    index_accum_next  = index_accum;
    red_hold_next     = red_hold;
    green_hold_next   = green_hold;
    blue_hold_next    = blue_hold;
    hex_hold_next     = hex_hold;
    comp_next         = comp;
    res               = NO_RESULT;
    redo              = 1'b0;

    if (end_of_input) begin
      if (state == S_ESC) res = key_res(K_ESCAPE, M_NONE);
    end else begin
      case (state)
        S_IDLE: redo = 1'b1;
        S_ESC: begin
          if (in_byte == CH_RBRK) state_next = S_OSC;
          else if (in_byte == CH_UO) state_next = S_SS3;
          else if (in_byte == CH_LBRK) state_next = S_CSI;
          else if (in_byte <= CH_SPACE) res = key_res(ctrl16, M_ALT | M_CTRL);
          else res = key_res(byte16, M_ALT);
        end
        S_OSC: if (in_byte == CH_4) state_next = S_C_SEMI;
        S_SS3: begin
          if (in_byte >= CH_UP && in_byte <= CH_US)
            res = key_res(K_F1 + {14'h0, in_byte[1:0]}, M_NONE);
        end
        S_CSI: begin
          case (in_byte)
            CH_LBRK: state_next = S_CSI_LB;
            CH_UA:   res = key_res(K_UP, M_NONE);
            CH_UB:   res = key_res(K_DOWN, M_NONE);
            CH_UC:   res = key_res(K_RIGHT, M_NONE);
            CH_UD:   res = key_res(K_LEFT, M_NONE);
            CH_1:    state_next = S_CSI1;
            CH_2:    state_next = S_CSI2;
            CH_4:    state_next = S_CSI4;
            CH_5: begin
              pending_key_next = K_PAGE_UP;
              state_next       = S_TILDE;
            end
            CH_6: begin
              pending_key_next = K_PAGE_DOWN;
              state_next       = S_TILDE;
            end
            CH_UH:   res = key_res(K_HOME, M_NONE);
            CH_UJ:   res = key_res(K_END, M_CTRL);
            CH_UK:   res = key_res(K_END, M_SHIFT);
            CH_UM:   state_next = S_MB;
            CH_UP:   res = key_res(K_DELETE, M_NONE);
            default: state_next = S_IDLE;
          endcase
        end
        S_CSI_LB: begin
          if (in_byte >= CH_UA && in_byte <= CH_UE)
            res = key_res(K_F1 + byte16 - {8'h00, CH_UA}, M_NONE);
        end
        S_CSI1: begin
          case (in_byte)
            CH_5: begin
              pending_key_next = K_F1 + 16'd4;
              state_next       = S_TILDE;
            end
            CH_7: begin
              pending_key_next = K_F1 + 16'd5;
              state_next       = S_TILDE;
            end
            CH_8: begin
              pending_key_next = K_F1 + 16'd6;
              state_next       = S_TILDE;
            end
            CH_9: begin
              pending_key_next = K_F1 + 16'd7;
              state_next       = S_TILDE;
            end
            CH_SEMI:  state_next = S_CSI1_MOD;
            CH_TILDE: res = key_res(K_HOME, M_NONE);
            default:  state_next = S_IDLE;
          endcase
        end
        S_CSI1_MOD: begin
          pending_mods_next = mod_b;
          state_next        = S_CSI1_FIN;
        end
        S_CSI1_FIN: begin
          case (in_byte)
            CH_UA:   res = key_res(K_UP, pending_mods);
            CH_UB:   res = key_res(K_DOWN, pending_mods);
            CH_UC:   res = key_res(K_RIGHT, pending_mods);
            CH_UD:   res = key_res(K_LEFT, pending_mods);
            CH_UP, CH_UQ, CH_UR, CH_US:
              res = key_res(K_F1 + {14'h0, in_byte[1:0]}, pending_mods);
            default: state_next = S_IDLE;
          endcase
        end
        S_CSI2: begin
          case (in_byte)
            CH_0: begin
              pending_key_next = K_F1 + 16'd8;
              state_next       = S_TILDE;
            end
            CH_1: begin
              pending_key_next = K_F1 + 16'd9;
              state_next       = S_TILDE;
            end
            CH_3: begin
              pending_key_next = K_F1 + 16'd10;
              state_next       = S_TILDE;
            end
            CH_4: begin
              pending_key_next = K_F1 + 16'd11;
              state_next       = S_TILDE;
            end
            CH_UJ:   res = key_res(K_HOME, M_SHIFT);
            CH_UK:   res = key_res(K_DELETE, M_SHIFT);
            default: state_next = S_IDLE;
          endcase
        end
        S_CSI4: if (in_byte == CH_TILDE) res = key_res(K_END, M_NONE);
        S_TILDE: begin
          if (in_byte == CH_TILDE) res = key_res(pending_key, M_NONE);
          else if (in_byte == CH_SEMI) state_next = S_TMOD;
        end
        S_TMOD: begin
          res        = key_res(pending_key, mod_b);
          state_next = S_TSKIP;
        end
        S_TSKIP: state_next = S_IDLE;
        S_MB: begin
          held_button_next = in_byte;
          state_next       = S_MX;
        end
        S_MX: begin
          held_x_next = {1'b0, in_byte} - {1'b0, CH_MOUSE};
          state_next  = S_MY;
        end
        S_MY: begin
          res              = NO_RESULT;
          res.valid        = 1'b1;
          res.kind         = EV_MOUSE;
          res.mouse_button = held_button;
          res.mouse_x      = $signed(held_x);
          res.mouse_y      = $signed({1'b0, in_byte} - {1'b0, CH_MOUSE});
        end
        S_C_SEMI: begin
          if (in_byte == CH_SEMI) state_next = S_C_IDX0;
          else redo = 1'b1;
        end
        S_C_IDX0: begin
          if (is_digit) begin
            index_accum_next = in_byte - CH_0;
            state_next       = S_C_IDX;
          end else begin
            redo = 1'b1;
          end
        end
        S_C_IDX: begin
          if (is_digit) begin
            index_accum_next = (idx_sum > 12'd255) ? 8'hFF : idx_sum[7:0];
            state_next       = S_C_IDX;
          end else if (in_byte == CH_SEMI) begin
            state_next = S_L_R;
          end else begin
            redo = 1'b1;
          end
        end
        S_L_R: begin
          if (in_byte == CH_LR) state_next = S_L_G;
          else redo = 1'b1;
        end
        S_L_G: begin
          if (in_byte == CH_LG) state_next = S_L_B;
          else redo = 1'b1;
        end
        S_L_B: begin
          if (in_byte == CH_LB) state_next = S_L_COLON;
          else redo = 1'b1;
        end
        S_L_COLON: begin
          if (in_byte == CH_COLON) begin
            state_next = S_CP0;
            comp_next  = 2'd0;
          end else begin
            redo = 1'b1;
          end
        end
        S_CP0: begin
          if (is_hex) begin
            hex_hold_next = hv[3:0];
            state_next    = S_CP1;
          end else begin
            redo = 1'b1;
          end
        end
        S_CP1: begin
          if (is_hex) begin
            case (comp)
              2'd0:    red_hold_next = {hex_hold, hv[3:0]};
              2'd1:    green_hold_next = {hex_hold, hv[3:0]};
              default: blue_hold_next = {hex_hold, hv[3:0]};
            endcase
            state_next = S_CP2;
          end else begin
            redo = 1'b1;
          end
        end
        S_CP2: begin
          if (is_hex) state_next = S_CP3;
          else redo = 1'b1;
        end
        S_CP3, S_CP4: begin
          if (state == S_CP3 && is_hex) begin
            state_next = S_CP4;
          end else if (in_byte == sep) begin
            if (comp < COMP_BLUE) begin
              comp_next  = comp + 2'd1;
              state_next = S_CP0;
            end else begin
              res              = NO_RESULT;
              res.valid        = 1'b1;
              res.kind         = EV_COLOUR;
              res.colour_index = index_accum;
              res.colour_red   = red_hold;
              res.colour_green = green_hold;
              res.colour_blue  = blue_hold;
            end
          end else begin
            redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase

      // A byte in idle, or one that does not fit a colour reply, is decoded as from idle.
      if (redo) begin
        if (in_byte == CH_ESC) state_next = S_ESC;
        else if (in_byte == CH_LF || in_byte == CH_CR) res = key_res(K_RETURN, M_NONE);
        else if (in_byte == CH_BS || in_byte == CH_DEL) res = key_res(K_BACKSPACE, M_NONE);
        else if (in_byte <= CH_SPACE) res = key_res(ctrl16, M_CTRL);
        else res = key_res(byte16, M_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pending_key  <= '0;
      pending_mods <= '0;
      held_button  <= '0;
      held_x       <= '0;
      index_accum  <= '0;
      red_hold     <= '0;
      green_hold   <= '0;
      blue_hold    <= '0;
      hex_hold     <= '0;
      comp         <= '0;
    end else if (step) begin
      state        <= state_next;
      pending_key  <= pending_key_next;
      pending_mods <= pending_mods_next;
      held_button  <= held_button_next;
      held_x       <= held_x_next;
      index_accum  <= index_accum_next;
      red_hold     <= red_hold_next;
      green_hold   <= green_hold_next;
      blue_hold    <= blue_hold_next;
      hex_hold     <= hex_hold_next;
      comp         <= comp_next;
    end
  end

endmodule
